// File: sv/unicycle_pose_integrator_top_defines.svh
// assertion macros shared by the pose integrator rtl
`ifndef UNICYCLE_POSE_INTEGRATOR_TOP_DEFINES_SVH
`define UNICYCLE_POSE_INTEGRATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define UPI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define UPI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/upi_pkg.sv
// shared types, microcode program and constants of the pose integrator
`default_nettype none
package upi_pkg;

	// register file
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKWARD_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE = 2'd2;
	localparam logic [15:0] FORWARD_SPEED_RST = 16'd25600;
	localparam logic [15:0] BACKWARD_SPEED_RST = 16'd12800;
	localparam logic [19:0] TURN_RATE_RST = 20'd16384;

	// stream widths
	localparam int unsigned IN_TDATA_W = 24;
	localparam int unsigned OUT_TDATA_W = 80;

	// cordic
	localparam int unsigned CORDIC_ITER_DEF = 16;
	localparam int unsigned ATAN_LEN = 24;
	localparam int unsigned ITER_W = $clog2(ATAN_LEN);
	localparam int unsigned CORDIC_W = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

	// microcode
	localparam int unsigned STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_LOAD = 3'd0;
	localparam step_t STEP_ITER = 3'd1;
	localparam step_t STEP_FIX = 3'd2;
	localparam step_t STEP_MULX = 3'd3;
	localparam step_t STEP_ACCX = 3'd4;
	localparam step_t STEP_ACCY = 3'd5;
	localparam step_t STEP_EMIT = 3'd6;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_LOOP,
		JMP_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		logic  ld;
		logic  iter;
		logic  fix;
		logic  mul;
		logic  mul_y;
		logic  acc_x;
		logic  acc_y;
		logic  emit;
		jmp_t  jmp;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic iter_last;
		logic out_free;
	} seq_stat_t;

	// control store, one word per step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = '0;
		unique case (step)
			STEP_LOAD: begin
				w.ld = 1'b1;
				w.jmp = JMP_WAIT_IN;
			end
			STEP_ITER: begin
				w.iter = 1'b1;
				w.jmp = JMP_LOOP;
				w.target = STEP_ITER;
			end
			STEP_FIX: begin
				w.fix = 1'b1;
				w.jmp = JMP_NEXT;
			end
			STEP_MULX: begin
				w.mul = 1'b1;
				w.jmp = JMP_NEXT;
			end
			STEP_ACCX: begin
				w.acc_x = 1'b1;
				w.mul = 1'b1;
				w.mul_y = 1'b1;
				w.jmp = JMP_NEXT;
			end
			STEP_ACCY: begin
				w.acc_y = 1'b1;
				w.jmp = JMP_NEXT;
			end
			STEP_EMIT: begin
				w.emit = 1'b1;
				w.jmp = JMP_WAIT_OUT;
				w.target = STEP_LOAD;
			end
			default: begin
				w.jmp = JMP_WAIT_OUT;
				w.target = STEP_LOAD;
			end
		endcase
		return w;
	endfunction

	// arctangent of 2^-i as a fraction of a turn, 2^32 per turn
	function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// File: sv/upi_seq.sv
// microcode sequencer: step counter, control store lookup and jumps
`default_nettype none
module upi_seq
	import upi_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire seq_stat_t stat,
	output ctrl_t          ctrl
);

	step_t pc_q;
	step_t pc_d;
	step_t pc_inc;

	// current control word
	assign ctrl = ucode(pc_q);
	assign pc_inc = pc_q + step_t'(1);

	// next step selection
	always_comb begin
		unique case (ctrl.jmp)
			JMP_NEXT:     pc_d = pc_inc;
			JMP_WAIT_IN:  pc_d = stat.in_fire ? pc_inc : pc_q;
			JMP_LOOP:     pc_d = stat.iter_last ? pc_inc : ctrl.target;
			JMP_WAIT_OUT: pc_d = stat.out_free ? ctrl.target : pc_q;
			default:      pc_d = STEP_LOAD;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LOAD;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/upi_cordic.sv
// rotation-mode cordic, one shift-add iteration per cycle, gives cos and sin
`default_nettype none
module upi_cordic
	import upi_pkg::*;
#(
	parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctrl_t              ctrl,
	input  wire logic [15:0]        heading,
	output logic signed [31:0]      cos_val,
	output logic signed [31:0]      sin_val,
	output logic                    iter_last
);

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERATIONS - 1);

	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic signed [CORDIC_W-1:0] dx, dy, da;
	logic [ITER_W-1:0]          cnt_q;
	logic                       flip_q;
	logic                       flip;
	logic signed [CORDIC_W-1:0] z0;

	// left half-plane angles rotate by half a turn
	assign flip = heading[15] ^ heading[14];
	assign z0 = CORDIC_W'(signed'({heading[14], heading[14:0], 16'h0000}));

	// shifted terms of this iteration
	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign da = CORDIC_W'({2'b00, atan_turn(cnt_q)});
	assign iter_last = (cnt_q == LAST_ITER);

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.ld) begin
			cnt_q <= '0;
		end else if (ctrl.iter) begin
			cnt_q <= cnt_q + ITER_W'(1);
		end
	end

	// vector and angle registers
	always_ff @(posedge clk) begin
		if (ctrl.ld) begin
			x_q <= CORDIC_GAIN_INV;
			y_q <= '0;
			z_q <= z0;
			flip_q <= flip;
		end else if (ctrl.iter) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end
		end
	end

	// undo the half-turn and hold the results
	always_ff @(posedge clk) begin
		if (ctrl.fix) begin
			cos_val <= flip_q ? 32'(-x_q) : 32'(x_q);
			sin_val <= flip_q ? 32'(-y_q) : 32'(y_q);
		end
	end

endmodule
`default_nettype wire

// File: sv/unicycle_pose_integrator_top.sv
// pose integrator: an accepted request passes the cordic iterations, then the fix-up,
// multiply, x and y accumulate and emit steps; requests are taken one at a time, paced by the
// single cordic shift-add stage looping once per iteration and the shared multiplier
// the input side is ready again while a finished result waits in the output register
// reset clears pose to zero, loads the speed registers with their defaults, idles
// the sequencer; no clearing pass, requests are taken in the first cycle after reset
`default_nettype none
`include "unicycle_pose_integrator_top_defines.svh"
module unicycle_pose_integrator_top
	import upi_pkg::*;
#(
	parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// tdata: key_forward, key_backward, key_left, key_right, step_time[15:0], zero pad
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// tdata: pos_x[31:0], pos_y[31:0], heading[15:0]
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	ctrl_t     ctrl;
	seq_stat_t stat;

	logic [15:0] fwd_speed_q;
	logic [15:0] bwd_speed_q;
	logic [19:0] turn_rate_q;

	logic signed [31:0] x_q, y_q;
	logic [15:0]        heading_q;

	logic               in_fire;
	logic               out_free;
	logic               iter_last;
	logic               kf, kb, kl, kr;
	logic [15:0]        dt;
	logic               go_fwd, go_bwd, vneg;
	logic signed [16:0] vel;
	logic               turn_pos, turn_neg;
	logic [35:0]        turn_prod;

	logic signed [32:0] p_q;
	logic [15:0]        dmag_q;
	logic               turn_pos_q, turn_neg_q;
	logic signed [31:0] cos_val, sin_val;
	logic signed [31:0] mul_op;
	logic signed [64:0] prod_q;
	logic signed [64:0] prod_rnd;
	logic signed [26:0] disp;
	logic signed [33:0] pos_sum;
	logic signed [31:0] pos_sat;
	logic signed [31:0] pos_cur;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_speed_q <= FORWARD_SPEED_RST;
			bwd_speed_q <= BACKWARD_SPEED_RST;
			turn_rate_q <= TURN_RATE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FORWARD_SPEED:  fwd_speed_q <= cfg_data[15:0];
				REG_BACKWARD_SPEED: bwd_speed_q <= cfg_data[15:0];
				REG_TURN_RATE:      turn_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and cordic unit
	assign stat = '{in_fire: in_fire, iter_last: iter_last, out_free: out_free};

	upi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	upi_cordic #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.heading   (heading_q),
		.cos_val   (cos_val),
		.sin_val   (sin_val),
		.iter_last (iter_last)
	);

	// request decode: speed and turn direction
	assign s_axis_tready = ctrl.ld;
	assign in_fire = s_axis_tvalid && ctrl.ld;
	assign kf = s_axis_tdata[0];
	assign kb = s_axis_tdata[1];
	assign kl = s_axis_tdata[2];
	assign kr = s_axis_tdata[3];
	assign dt = s_axis_tdata[19:4];
	assign go_fwd = kf && !kb;
	assign go_bwd = kb && !kf;
	assign vneg = go_bwd && (bwd_speed_q != 16'd0);
	assign vel = go_fwd ? signed'({1'b0, fwd_speed_q}) :
		(go_bwd ? -signed'({1'b0, bwd_speed_q}) : 17'sd0);
	// turn is mirrored while reversing
	assign turn_pos = vneg ? (kl && !kr) : (kr && !kl);
	assign turn_neg = vneg ? (kr && !kl) : (kl && !kr);
	assign turn_prod = 36'(turn_rate_q) * 36'(dt) + 36'd32768;

	// request capture: speed times dt and rounded heading step
	always_ff @(posedge clk) begin
		if (in_fire) begin
			p_q <= 33'(vel) * 33'(signed'({1'b0, dt}));
			dmag_q <= turn_prod[31:16];
			turn_pos_q <= turn_pos;
			turn_neg_q <= turn_neg;
		end
	end

	// shared multiplier, cos then sin
	assign mul_op = ctrl.mul_y ? sin_val : cos_val;
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= p_q * mul_op;
		end
	end

	// round to nearest, add to the coordinate and saturate
	assign prod_rnd = prod_q + 65'sd137438953472;
	assign disp = prod_rnd[64:38];
	assign pos_cur = ctrl.acc_y ? y_q : x_q;
	assign pos_sum = 34'(pos_cur) + 34'(disp);
	always_comb begin
		priority if (pos_sum > 34'sd2147483647) begin
			pos_sat = 32'sh7FFFFFFF;
		end else if (pos_sum < -34'sd2147483648) begin
			pos_sat = 32'sh80000000;
		end else begin
			pos_sat = pos_sum[31:0];
		end
	end

	// pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			heading_q <= '0;
		end else begin
			if (ctrl.acc_x) begin
				x_q <= pos_sat;
			end
			if (ctrl.acc_y) begin
				y_q <= pos_sat;
				if (turn_pos_q) begin
					heading_q <= heading_q + dmag_q;
				end else if (turn_neg_q) begin
					heading_q <= heading_q - dmag_q;
				end
			end
		end
	end

	// output register
	assign out_free = !m_axis_tvalid || m_axis_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			m_axis_tdata <= {heading_q, y_q, x_q};
		end
	end

	// checks
	`UPI_ASSERT_NXT(a_accept_starts_cordic, in_fire, ctrl.iter, "request accepted but cordic did not start")
	`UPI_ASSERT_NXT(a_heading_only_on_update, !ctrl.acc_y, $stable(heading_q), "heading changed outside update step")
	`UPI_ASSERT_IMP(a_result_from_emit, $rose(m_axis_tvalid), $past(ctrl.emit), "result raised without emit step")

endmodule
`default_nettype wire

// File: verif/unicycle_pose_integrator_top_tb.sv
// self-checking testbench for the unicycle pose integrator
module unicycle_pose_integrator_top_tb;
	import upi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CORDIC_ITERS = 16;
	localparam int unsigned ATAN_STEPS = 24;
	localparam int WATCHDOG_LIMIT = 1000;

	// request field positions inside s_axis_tdata
	localparam int KEY_FWD = 0;
	localparam int KEY_BWD = 1;
	localparam int KEY_LEFT = 2;
	localparam int KEY_RIGHT = 3;
	localparam int DT_LSB = 4;

	// button patterns
	localparam logic [3:0] KEYS_FWD = 4'b0001;
	localparam logic [3:0] KEYS_BWD = 4'b0010;
	localparam logic [3:0] KEYS_LEFT = 4'b0100;
	localparam logic [3:0] KEYS_RIGHT = 4'b1000;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// rotation constants: 1/K in Q1.30, half of 2^38 for rounding, atan(2^-i) in 2^32/turn
	localparam longint GAIN_INV_Q30 = 64'sd652032874;
	localparam longint ROUND_Q38 = 64'sh20_0000_0000;
	localparam longint ATAN_TURN [ATAN_STEPS] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
		64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        heading;
	} pose_t;

	// tracks drive settings and pose, predicts each step and checks results in order
	class pose_scoreboard;
		logic [15:0]        fwd_speed;
		logic [15:0]        bwd_speed;
		logic [19:0]        turn_speed;
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic [15:0]        hdg;
		pose_t              pending_poses[$];
		int                 steps;
		int                 checked;
		int                 mismatches;
		int                 reg_writes;
		int                 limit_hits;
		int                 wraps;

		function new();
			fwd_speed = FORWARD_SPEED_RST;
			bwd_speed = BACKWARD_SPEED_RST;
			turn_speed = TURN_RATE_RST;
			x_pos = '0;
			y_pos = '0;
			hdg = '0;
			steps = 0;
			checked = 0;
			mismatches = 0;
			reg_writes = 0;
			limit_hits = 0;
			wraps = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			reg_writes++;
			case (idx)
				REG_FORWARD_SPEED: fwd_speed = val[15:0];
				REG_BACKWARD_SPEED: bwd_speed = val[15:0];
				REG_TURN_RATE: turn_speed = val[19:0];
				default: ;
			endcase
		endfunction

		// cos and sin of a heading in Q1.30, left half-plane folded by half a turn
		function void heading_cos_sin(input logic [15:0] h, output longint c, output longint s);
			logic [31:0] ang;
			bit flip;
			longint x, y, z, dx, dy;
			ang = {h, 16'h0000};
			flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
			if (flip) ang = ang - 32'h8000_0000;
			z = longint'(signed'(ang));
			x = GAIN_INV_Q30;
			y = 0;
			for (int i = 0; i < int'(CORDIC_ITERS) && i < int'(ATAN_STEPS); i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_TURN[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_TURN[i];
				end
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			c = x;
			s = y;
		endfunction

		function longint clamp32(longint v);
			if (v > longint'(32'h7fff_ffff)) return longint'(32'h7fff_ffff);
			if (v < -longint'(32'h8000_0000)) return -longint'(32'h8000_0000);
			return v;
		endfunction

		// advance the pose by one accepted step and queue the expected result
		function void note_step(logic [IN_TDATA_W-1:0] req);
			longint dt, v, c, s, p, dmag, nx, ny;
			int turn;
			logic [15:0] old_hdg;
			pose_t nxt;
			dt = longint'(req[DT_LSB +: 16]);
			v = 0;
			turn = 0;
			if (req[KEY_FWD] && !req[KEY_BWD]) v = longint'(fwd_speed);
			else if (req[KEY_BWD] && !req[KEY_FWD]) v = -longint'(bwd_speed);
			if (req[KEY_LEFT] && !req[KEY_RIGHT]) turn = -1;
			else if (req[KEY_RIGHT] && !req[KEY_LEFT]) turn = 1;
			if (v < 0) turn = -turn;

			// move along the old heading, rounded to nearest and saturated
			heading_cos_sin(hdg, c, s);
			p = v * dt;
			nx = clamp32(longint'(x_pos) + ((p * c + ROUND_Q38) >>> 38));
			ny = clamp32(longint'(y_pos) + ((p * s + ROUND_Q38) >>> 38));
			x_pos = nx[31:0];
			y_pos = ny[31:0];
			if (x_pos == 32'sh7fff_ffff || x_pos == 32'sh8000_0000 ||
			    y_pos == 32'sh7fff_ffff || y_pos == 32'sh8000_0000) limit_hits++;

			// then turn, rounded half up, wrapping modulo one turn
			dmag = (longint'(turn_speed) * dt + 32768) >>> 16;
			old_hdg = hdg;
			if (turn > 0) begin
				hdg = hdg + dmag[15:0];
				if (hdg < old_hdg) wraps++;
			end else if (turn < 0) begin
				hdg = hdg - dmag[15:0];
				if (hdg > old_hdg) wraps++;
			end

			nxt.pos_x = x_pos;
			nxt.pos_y = y_pos;
			nxt.heading = hdg;
			pending_poses.push_back(nxt);
			steps++;
		endfunction

		function void check_pose(logic [OUT_TDATA_W-1:0] d);
			pose_t got, want;
			got.pos_x = d[31:0];
			got.pos_y = d[63:32];
			got.heading = d[79:64];
			if (pending_poses.size() == 0) begin
				$display("%0t: pose with no request pending, x=%0d y=%0d heading=%0d",
					$time, got.pos_x, got.pos_y, got.heading);
				mismatches++;
				return;
			end
			want = pending_poses.pop_front();
			checked++;
			if (got.pos_x !== want.pos_x) begin
				$display("%0t: pos_x mismatch, expected %0d, actual %0d",
					$time, want.pos_x, got.pos_x);
				mismatches++;
			end
			if (got.pos_y !== want.pos_y) begin
				$display("%0t: pos_y mismatch, expected %0d, actual %0d",
					$time, want.pos_y, got.pos_y);
				mismatches++;
			end
			if (got.heading !== want.heading) begin
				$display("%0t: heading mismatch, expected %0d, actual %0d",
					$time, want.heading, got.heading);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;   // key_forward, key_backward, key_left, key_right, step_time, pad
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // pos_x, pos_y, heading
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pose_scoreboard sb;
	bit idling;
	int stall_left;
	int idle_cycles;

	unicycle_pose_integrator_top #(
		.CORDIC_ITERATIONS(CORDIC_ITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: stalls at random while idling is on
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// observe accepted requests, results and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) sb.note_step(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) sb.check_pose(m_axis_tdata);
			if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d poses outstanding",
				$time, idle_cycles, sb.pending_poses.size());
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one request, with an optional random gap before it; valid stays high on return
	task automatic send_step(input logic [3:0] keys, input logic [15:0] dt);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tdata <= {4'b0000, dt, keys};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// random buttons, biased toward driving, with extreme step times now and then
	task automatic send_random(input int n);
		logic [3:0] keys;
		logic [15:0] dt;
		repeat (n) begin
			keys = 4'($urandom);
			if ($urandom_range(0, 1) == 1)
				keys[1:0] = ($urandom_range(0, 1) == 1) ? KEYS_FWD[1:0] : KEYS_BWD[1:0];
			case ($urandom_range(0, 7))
				0: dt = 16'h0000;
				1: dt = 16'hffff;
				default: dt = 16'($urandom);
			endcase
			send_step(keys, dt);
		end
	endtask

	// stop sending and wait for every outstanding pose, after first letting the last
	// accepted request be noted
	task automatic drain_poses();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_poses.size() != 0) @(posedge clk);
	endtask

	// register write request; valid stays high on return
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// new speeds, written only once the block is idle
	task automatic set_drive(input logic [CFG_DATA_W-1:0] fwd, input logic [CFG_DATA_W-1:0] bwd,
			input logic [CFG_DATA_W-1:0] trate);
		drain_poses();
		write_reg(REG_FORWARD_SPEED, fwd);
		write_reg(REG_BACKWARD_SPEED, bwd);
		write_reg(REG_TURN_RATE, trate);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_axis_tready = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		idling = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset speeds: every button combination at full step time
		for (int k = 0; k < 16; k++) send_step(4'(k), 16'hffff);
		// heading wraps below zero, half-up rounding ties, tiny and patterned step times
		send_step(KEYS_LEFT, 16'hffff);
		send_step(KEYS_LEFT, 16'hffff);
		send_step(KEYS_RIGHT, 16'd2);
		send_step(KEYS_LEFT, 16'd2);
		send_step(KEYS_FWD, 16'h0000);
		send_step(KEYS_FWD, 16'h0001);
		send_step(KEYS_FWD, 16'h5555);
		send_step(KEYS_BWD | KEYS_RIGHT, 16'haaaa);

		// full-scale speeds
		set_drive(20'h0ffff, 20'h0ffff, 20'hfffff);
		send_random(150);

		// everything zero
		set_drive(20'h00000, 20'h00000, 20'h00000);
		send_random(60);

		// random settings with junk above the speed widths, plus the unused index
		drain_poses();
		write_reg(REG_SPARE, 20'($urandom));
		set_drive(20'($urandom), 20'($urandom), 20'($urandom));
		send_random(150);

		// zero reverse speed: backward turns are not mirrored
		set_drive(20'($urandom), 20'h00000, 20'($urandom_range(1, 1048575)));
		send_random(100);

		// square up to heading zero, then run into both x limits
		set_drive(20'h0ffff, 20'h0ffff, 20'h10000);
		send_step(KEYS_RIGHT, 16'h0000 - sb.hdg);
		repeat (260) send_step(KEYS_FWD, 16'hffff);
		repeat (260) send_step(KEYS_BWD, 16'hffff);

		// last stretch at full rate, no stalls on either side
		idling = 1'b0;
		set_drive(20'($urandom), 20'($urandom), 20'($urandom));
		send_random(150);

		drain_poses();
		repeat (CORDIC_ITERS + 8) @(posedge clk);

		$display("run: %0d steps predicted, %0d poses compared, %0d register writes",
			sb.steps, sb.checked, sb.reg_writes);
		$display("run: %0d poses at a position limit, %0d heading wraps, zero to full-scale speeds",
			sb.limit_hits, sb.wraps);
		if (sb.pending_poses.size() != 0)
			$display("%0t: %0d expected poses never arrived", $time, sb.pending_poses.size());
		if (sb.mismatches == 0 && sb.pending_poses.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
